[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL; empty when building for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/mlink_pkg.sv]
package mlink_pkg;

    // Input beat codes
    localparam logic [1:0] MODE_TICK     = 2'd0;
    localparam logic [1:0] MODE_TRAFFIC  = 2'd1;
    localparam logic [1:0] MODE_OVERRIDE = 2'd2;

    // Frame timing
    localparam logic [3:0] FRAME_TICKS    = 4'd10;
    localparam logic [2:0] MUTE_HIGH      = 3'd3;
    localparam logic [2:0] UNMUTE_HIGH    = 3'd7;

    // Readback decoding
    localparam logic [1:0] ENOUGH         = 2'd3;
    localparam logic [6:0] TIME_MAX       = 7'd127;
    localparam logic [3:0] SILENCE_RELOAD = 4'd12;
    localparam logic [3:0] SILENCE_RESET  = 4'd10;

    // Configuration reset value
    localparam logic [7:0] TIMEOUT_RESET  = 8'd13;

    typedef struct packed {
        logic [1:0] mode;
        logic       status_pin;
        logic       override_enable;
        logic       override_unmute;
    } t_item;

    typedef struct packed {
        logic signal_out;
        logic audio_ok_led;
        logic software_override;
        logic software_unmute;
        logic traffic_derived;
        logic traffic_unmute;
    } t_req_status;

    typedef struct packed {
        logic hw_valid;
        logic hw_unmute;
    } t_hw_status;

    // Time within one tick of the nominal count
    function automatic logic is_near(input logic [6:0] v, input logic [2:0] c);
        logic [7:0] v_w;
        logic [7:0] c_w;
        v_w = {1'b0, v};
        c_w = {5'd0, c};
        return (v_w + 8'd1 == c_w) || (v_w == c_w) || (v_w == c_w + 8'd1);
    endfunction

endpackage

[rtl/core/mlink_req_tx.sv]
module mlink_req_tx import mlink_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_en,
    input  t_item       i_item,
    output t_req_status o_req
);

    logic [7:0] r_timeout, n_timeout;
    logic [7:0] r_countdown, n_countdown;
    logic       r_ov_on, n_ov_on;
    logic       r_ov_val, n_ov_val;
    logic       r_req, n_req;
    logic       r_req_known, n_req_known;
    logic [2:0] r_pend_high, n_pend_high;
    logic [2:0] r_cur_high, n_cur_high;
    logic [3:0] r_phase, n_phase;

    logic [7:0] v_cd;
    logic       v_req;
    logic [2:0] v_pend;
    logic [3:0] v_phase;

    // Work out the request and frame for a tick
    always_comb begin
        v_cd  = (r_countdown != 8'd0) ? r_countdown - 8'd1 : r_countdown;
        v_req = r_ov_on ? r_ov_val : (v_cd != 8'd0);
        v_pend = r_pend_high;
        if (!r_req_known || v_req != r_req) begin
            v_pend = v_req ? UNMUTE_HIGH : MUTE_HIGH;
        end
        v_phase = r_phase + 4'd1;

        o_req.signal_out        = r_phase < {1'b0, r_cur_high};
        o_req.audio_ok_led      = v_req;
        o_req.software_override = r_ov_on;
        o_req.software_unmute   = r_ov_on & r_ov_val;
        o_req.traffic_derived   = ~r_ov_on;
        o_req.traffic_unmute    = ~r_ov_on & (v_cd != 8'd0);
    end

    // Next state per beat code
    always_comb begin
        n_timeout   = i_cfg_we ? i_cfg_data : r_timeout;
        n_countdown = r_countdown;
        n_ov_on     = r_ov_on;
        n_ov_val    = r_ov_val;
        n_req       = r_req;
        n_req_known = r_req_known;
        n_pend_high = r_pend_high;
        n_cur_high  = r_cur_high;
        n_phase     = r_phase;
        if (i_en) begin
            case (i_item.mode)
                MODE_TRAFFIC: begin
                    n_countdown = r_timeout;
                end
                MODE_OVERRIDE: begin
                    n_ov_on  = i_item.override_enable;
                    n_ov_val = i_item.override_unmute;
                end
                MODE_TICK: begin
                    n_countdown = v_cd;
                    n_req       = v_req;
                    n_req_known = 1'b1;
                    n_pend_high = v_pend;
                    if (v_phase >= FRAME_TICKS) begin
                        n_phase    = 4'd0;
                        n_cur_high = v_pend;
                    end else begin
                        n_phase    = v_phase;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_RESET;
            r_countdown <= 8'd0;
            r_ov_on     <= 1'b0;
            r_ov_val    <= 1'b0;
            r_req       <= 1'b0;
            r_req_known <= 1'b0;
            r_pend_high <= MUTE_HIGH;
            r_cur_high  <= MUTE_HIGH;
            r_phase     <= 4'd0;
        end else begin
            r_timeout   <= n_timeout;
            r_countdown <= n_countdown;
            r_ov_on     <= n_ov_on;
            r_ov_val    <= n_ov_val;
            r_req       <= n_req;
            r_req_known <= n_req_known;
            r_pend_high <= n_pend_high;
            r_cur_high  <= n_cur_high;
            r_phase     <= n_phase;
        end
    end

endmodule

[rtl/core/mlink_pin_rx.sv]
module mlink_pin_rx import mlink_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_tick,
    input  logic       i_pin,
    output t_hw_status o_hw
);

    logic       r_last, r_last_known;
    logic [6:0] r_high, n_high;
    logic [6:0] r_low, n_low;
    logic [3:0] r_silence, n_silence;
    logic [1:0] r_active, n_active;
    logic [1:0] r_inactive, n_inactive;
    logic [1:0] r_unknown, n_unknown;
    logic       r_hw_valid, n_hw_valid;
    logic       r_hw_unmute, n_hw_unmute;
    logic       v_changed;

    // Measure high and low times and classify each frame on the rising edge
    always_comb begin
        n_high      = r_high;
        n_low       = r_low;
        n_silence   = r_silence;
        n_active    = r_active;
        n_inactive  = r_inactive;
        n_unknown   = r_unknown;
        n_hw_valid  = r_hw_valid;
        n_hw_unmute = r_hw_unmute;
        v_changed   = !r_last_known || (i_pin != r_last);

        if (i_pin && n_high < TIME_MAX) begin
            n_high = n_high + 7'd1;
        end
        if (!i_pin && n_low < TIME_MAX) begin
            n_low = n_low + 7'd1;
        end

        if (v_changed) begin
            n_silence = SILENCE_RELOAD;
            if (i_pin) begin
                if (is_near(n_high, UNMUTE_HIGH) && is_near(n_low, MUTE_HIGH)) begin
                    n_inactive = 2'd0;
                    n_unknown  = 2'd0;
                    if (r_active < ENOUGH) begin
                        n_active = r_active + 2'd1;
                    end else begin
                        n_hw_valid  = 1'b1;
                        n_hw_unmute = 1'b1;
                    end
                end else if (is_near(n_high, MUTE_HIGH) && is_near(n_low, UNMUTE_HIGH)) begin
                    n_active  = 2'd0;
                    n_unknown = 2'd0;
                    if (r_inactive < ENOUGH) begin
                        n_inactive = r_inactive + 2'd1;
                    end else begin
                        n_hw_valid  = 1'b1;
                        n_hw_unmute = 1'b0;
                    end
                end else begin
                    n_active   = 2'd0;
                    n_inactive = 2'd0;
                    if (r_unknown < ENOUGH) begin
                        n_unknown = r_unknown + 2'd1;
                    end
                end
                n_high = 7'd0;
                n_low  = 7'd0;
            end
        end

        // Count down silence; running out counts as an unknown frame
        if (n_silence != 4'd0) begin
            n_silence = n_silence - 4'd1;
        end
        if (n_silence == 4'd0) begin
            n_silence = SILENCE_RELOAD;
            if (n_unknown < ENOUGH) begin
                n_unknown = n_unknown + 2'd1;
            end
        end

        // Drop validity after enough unknown frames
        if (n_unknown >= ENOUGH) begin
            n_active   = 2'd0;
            n_inactive = 2'd0;
            n_hw_valid = 1'b0;
        end

        o_hw.hw_valid  = n_hw_valid;
        o_hw.hw_unmute = n_hw_unmute;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last       <= 1'b0;
            r_last_known <= 1'b0;
            r_high       <= 7'd0;
            r_low        <= 7'd0;
            r_silence    <= SILENCE_RESET;
            r_active     <= 2'd0;
            r_inactive   <= 2'd0;
            r_unknown    <= 2'd0;
            r_hw_valid   <= 1'b0;
            r_hw_unmute  <= 1'b0;
        end else if (i_tick) begin
            r_last       <= i_pin;
            r_last_known <= 1'b1;
            r_high       <= n_high;
            r_low        <= n_low;
            r_silence    <= n_silence;
            r_active     <= n_active;
            r_inactive   <= n_inactive;
            r_unknown    <= n_unknown;
            r_hw_valid   <= n_hw_valid;
            r_hw_unmute  <= n_hw_unmute;
        end
    end

endmodule

[rtl/core/mute_request_duty_cycle_link.sv]
// Path: a beat enters the input register on acceptance; a tick's status is loaded into
// the result register when the beat advances, which waits while that register is stalled.
// Throughput: one beat per cycle via the input register while the output is not stalled.
// Traffic and override beats update state and give no result.
// Reset: synchronous, active low; resets all but the data registers; timeout set to 13.
`include "assert_macros.svh"
module mute_request_duty_cycle_link import mlink_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_mode,
    input  logic       i_status_pin,
    input  logic       i_override_enable,
    input  logic       i_override_unmute,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_signal_out,
    output logic       o_audio_ok_led,
    output logic       o_status_valid,
    output logic       o_software_override,
    output logic       o_software_unmute,
    output logic       o_traffic_derived,
    output logic       o_traffic_unmute,
    output logic       o_hardware_valid,
    output logic       o_hardware_unmute,
    output logic       o_status_changed
);

    logic        r_in_valid;
    t_item       r_in;
    logic        w_adv;
    logic        w_tick;
    t_req_status w_req;
    t_hw_status  w_hw;
    logic [6:0]  w_status;
    logic        r_out_valid;
    t_req_status r_req;
    t_hw_status  r_hw;
    logic        r_changed;
    logic [6:0]  r_reported;
    logic        r_reported_known;

    // Move the held beat on whenever the result register is free or being taken
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign w_tick     = w_adv && (r_in.mode == MODE_TICK);
    assign o_in_ready = !r_in_valid || w_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in.mode            <= i_mode;
            r_in.status_pin      <= i_status_pin;
            r_in.override_enable <= i_override_enable;
            r_in.override_unmute <= i_override_unmute;
        end
    end

    mlink_req_tx u_req_tx (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_en       (w_adv),
        .i_item     (r_in),
        .o_req      (w_req)
    );

    mlink_pin_rx u_pin_rx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (w_tick),
        .i_pin   (r_in.status_pin),
        .o_hw    (w_hw)
    );

    // Assemble the status word
    assign w_status = {w_hw.hw_unmute, w_hw.hw_valid, w_req.traffic_unmute,
                       w_req.traffic_derived, w_req.software_unmute,
                       w_req.software_override, 1'b1};

    // Result register and last reported status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid      <= 1'b0;
            r_reported       <= 7'd0;
            r_reported_known <= 1'b0;
        end else if (w_tick) begin
            r_out_valid      <= 1'b1;
            r_reported       <= w_status;
            r_reported_known <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid      <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tick) begin
            r_req     <= w_req;
            r_hw      <= w_hw;
            r_changed <= !r_reported_known || (w_status != r_reported);
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_signal_out        = r_req.signal_out;
    assign o_audio_ok_led      = r_req.audio_ok_led;
    assign o_status_valid      = 1'b1;
    assign o_software_override = r_req.software_override;
    assign o_software_unmute   = r_req.software_unmute;
    assign o_traffic_derived   = r_req.traffic_derived;
    assign o_traffic_unmute    = r_req.traffic_unmute;
    assign o_hardware_valid    = r_hw.hw_valid;
    assign o_hardware_unmute   = r_hw.hw_unmute;
    assign o_status_changed    = r_changed;

    // A processed tick always lands in the result register
    `ASSERT_NEXT(a_tick_gives_result, i_clk, i_rst_n, w_tick, r_out_valid)
    // A held beat stays put while the result register is stalled
    `ASSERT_NEXT(a_hold_on_stall, i_clk, i_rst_n, r_in_valid && r_out_valid && !i_out_ready, r_in_valid)
    // The request has exactly one source
    `ASSERT_SAME(a_one_source, i_clk, i_rst_n, r_out_valid, r_req.software_override != r_req.traffic_derived)

endmodule
